[design/pair_product_search_core_macros.svh]
// Assertion macros for the pair product search core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PAIR_PRODUCT_SEARCH_CORE_MACROS_SVH
`define PAIR_PRODUCT_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define PPS_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PPS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[design/pps_pkg.sv]
// Shared types for the pair product search core.
// No dependencies; used by the channel interfaces and the top level.
package pps_pkg;

    localparam int ELEM_W = 32;
    localparam int PROD_W = 64;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

[design/pps_item_if.sv]
// Input channel: one array element per item, with the last-of-set flag.
// Depends on pps_pkg.
interface pps_item_if
    import pps_pkg::*;
();
    logic  valid;
    logic  ready;
    elem_t element_value;
    logic  last_element;

    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

[design/pps_result_if.sv]
// Result channel: search outcome and overflow flag, one item per data set.
// Depends on pps_pkg.
interface pps_result_if
    import pps_pkg::*;
();
    logic valid;
    logic ready;
    logic pair_found;
    logic overflow;

    modport source (output valid, output pair_found, output overflow, input ready);
    modport sink   (input valid, input pair_found, input overflow, output ready);
endinterface

[design/pps_cfg_if.sv]
// Configuration write channel carrying the target product.
// Depends on pps_pkg.
interface pps_cfg_if
    import pps_pkg::*;
();
    logic  valid;
    logic  ready;
    prod_t target_product;

    modport source (output valid, output target_product, input ready);
    modport sink   (input valid, input target_product, output ready);
endinterface

[design/pair_product_search_core.sv]
// Pair product search core: element store, pair sequencer, shared multiplier.
// Depends on pps_pkg, the pps_*_if interfaces and the assertion macro header.
//
// Elements load at one item per cycle, while the core is in its load state,
// into an on-chip store of MAX_ELEMENTS entries; extras are dropped and
// flagged as overflow. The item marked last starts a search over all pairs of
// kept elements, during which the input is not ready. The search uses one
// 32x32 signed multiplier and one 64-bit compare, fed through the single read
// port of the store: each pair goes through read, multiply and compare, and
// each first element adds a read and a load before its pairs. The search ends
// early on the first match, and its result is handed to the output register
// once that register is free.
// The result register lets the next set start loading while the previous
// result waits. The target register may be written whenever the core is idle.
`include "pair_product_search_core_macros.svh"

module pair_product_search_core
    import pps_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    pps_item_if.sink            items,
    pps_result_if.source        results,
    pps_cfg_if.sink             cfg
);

    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    // Sequencer states
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_LDA  = 3'd2;
    localparam logic [2:0] S_RDB  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_seen_reg, ovf_seen_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic              found_reg, found_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_found_reg, res_found_next;
    logic              res_ovf_reg, res_ovf_next;
    prod_t             target_reg;
    elem_t             a_reg;
    elem_t             rd_data_reg;
    prod_t             prod_reg;

    elem_t             store_mem [MAX_ELEMENTS];
    logic [ADDR_W-1:0] rd_addr;
    logic              item_accept;
    logic              has_room;
    logic              mem_wr;
    logic [CNT_W-1:0]  count_loaded;

    // Handshakes
    assign items.ready       = (state_reg == S_LOAD);
    assign cfg.ready         = 1'b1;
    assign item_accept       = items.valid && items.ready;
    assign results.valid     = res_valid_reg;
    assign results.pair_found = res_found_reg;
    assign results.overflow  = res_ovf_reg;

    assign has_room     = (count_reg < CNT_W'(MAX_ELEMENTS));
    assign mem_wr       = item_accept && has_room;
    assign count_loaded = has_room ? count_reg + CNT_W'(1) : count_reg;
    assign rd_addr      = (state_reg == S_RDA) ? i_reg : j_reg;

    // Element store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            store_mem[count_reg[ADDR_W-1:0]] <= items.element_value;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    // Datapath: operand hold and the shared multiplier
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LDA)
        begin
            a_reg <= rd_data_reg;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(a_reg) * PROD_W'(rd_data_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_seen_next  = ovf_seen_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        found_next     = found_reg;
        res_valid_next = res_valid_reg;
        res_found_next = res_found_reg;
        res_ovf_next   = res_ovf_reg;

        if (results.valid && results.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (item_accept)
                begin
                    count_next = count_loaded;
                    if (!has_room)
                    begin
                        ovf_seen_next = 1'b1;
                    end
                    if (items.last_element)
                    begin
                        found_next = 1'b0;
                        i_next     = '0;
                        state_next = (count_loaded < CNT_W'(2)) ? S_DONE : S_RDA;
                    end
                end
            end
            S_RDA:
            begin
                state_next = S_LDA;
            end
            S_LDA:
            begin
                j_next     = i_reg + ADDR_W'(1);
                state_next = S_RDB;
            end
            S_RDB:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (prod_reg == target_reg)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (CNT_W'(j_reg) + CNT_W'(1) == count_reg)
                begin
                    // row exhausted: next first element, or no pairs left
                    if (CNT_W'(i_reg) + CNT_W'(2) == count_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + ADDR_W'(1);
                        state_next = S_RDA;
                    end
                end
                else
                begin
                    j_next     = j_reg + ADDR_W'(1);
                    state_next = S_RDB;
                end
            end
            S_DONE:
            begin
                // hand off once the result register is free
                if (!res_valid_reg || results.ready)
                begin
                    res_valid_next = 1'b1;
                    res_found_next = found_reg;
                    res_ovf_next   = ovf_seen_reg;
                    count_next     = '0;
                    ovf_seen_next  = 1'b0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_seen_reg  <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            res_found_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
            target_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_seen_reg  <= ovf_seen_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            res_found_reg <= res_found_next;
            res_ovf_reg   <= res_ovf_next;
            if (cfg.valid && cfg.ready)
            begin
                target_reg <= cfg.target_product;
            end
        end
    end

    // Checks
    `PPS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ELEMENTS), "element count past capacity")
    `PPS_ASSERT_NOW(a_row_in_range, state_reg == S_LDA, CNT_W'(i_reg) + CNT_W'(1) < count_reg, "first element index has no partner")
    `PPS_ASSERT_NOW(a_col_in_range, state_reg == S_CMP, (j_reg > i_reg) && (CNT_W'(j_reg) < count_reg), "second element index out of range")
    `PPS_ASSERT_NEXT(a_done_handoff, state_reg == S_DONE && (!res_valid_reg || results.ready), results.valid && state_reg == S_LOAD && count_reg == '0, "result not handed off")

endmodule
